@@ hw/rtl/xsr_pkg.sv @@
// ----------------------------------------------------------------------------
// xsr_pkg: shared types and constants for the xoshiro256++ generator
// Holds the state word types, the command codes, the rotate and shift
// amounts, and the jump polynomials.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package xsr_pkg;

  typedef logic [63:0]      word_t;
  typedef word_t [3:0]      state_t;

  // Command codes carried in the func field
  typedef enum logic [1:0] {
    FUNC_NEXT      = 2'd0,
    FUNC_JUMP      = 2'd1,
    FUNC_LONG_JUMP = 2'd2,
    FUNC_LOAD      = 2'd3
  } func_e;

  localparam int unsigned ROT_OUT = 23;
  localparam int unsigned ROT_S3  = 45;
  localparam int unsigned SHIFT_T = 17;

  // Jump polynomials, word 0 at index 0
  localparam state_t JUMP_POLY = {
    64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
    64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba
  };
  localparam state_t LONG_JUMP_POLY = {
    64'h39109bb02acbe635, 64'h77710069854ee241,
    64'hc5004e441c522fb3, 64'h76e15d3efefdcbbf
  };

  // Rotate left by a constant amount
  function automatic word_t rotl(word_t x, int unsigned k);
    return (x << k) | (x >> (64 - k));
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/xsr_if.sv @@
// ----------------------------------------------------------------------------
// xsr_if: valid/ready channels of the xoshiro256++ generator
// Command channel (func and seed words) and random value channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface xsr_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [63:0] seed_word0;
  logic [63:0] seed_word1;
  logic [63:0] seed_word2;
  logic [63:0] seed_word3;

  modport source (output valid, func, seed_word0, seed_word1, seed_word2, seed_word3,
                  input ready);
  modport sink   (input valid, func, seed_word0, seed_word1, seed_word2, seed_word3,
                  output ready);
endinterface

interface xsr_rnd_if;
  logic        valid;
  logic        ready;
  logic [63:0] random_value;

  modport source (output valid, random_value, input ready);
  modport sink   (input valid, random_value, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/xsr_step.sv @@
// ----------------------------------------------------------------------------
// xsr_step: one xoshiro256 state update
// Xor/shift/rotate update of the four state words; the shared unit that
// next commands use once and jump walks use 256 times.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module xsr_step (
  input  wire xsr_pkg::state_t state_i,
  output xsr_pkg::state_t      state_o
);
  import xsr_pkg::*;

  word_t t;
  word_t s0, s1, s2, s3;

  always_comb begin
    t  = state_i[1] << SHIFT_T;
    s2 = state_i[2] ^ state_i[0];
    s3 = state_i[3] ^ state_i[1];
    s1 = state_i[1] ^ s2;
    s0 = state_i[0] ^ s3;
    state_o[0] = s0;
    state_o[1] = s1;
    state_o[2] = s2 ^ t;
    state_o[3] = rotl(s3, ROT_S3);
  end

endmodule

`default_nettype wire

@@ hw/rtl/xoshiro256_plusplus_generator.sv @@
// ----------------------------------------------------------------------------
// xoshiro256_plusplus_generator: xoshiro256++ random source with jumps
// Command-driven generator: next, jump, long jump and seed load.
// ----------------------------------------------------------------------------
// When a next command is accepted, s0+s3 and s0 are registered and the state
// advances; the finish state then, once the output register is free, forms
// rotl(sum,23)+s0 into the output register, after which the next command is
// accepted. A load writes the seed words into the state when it is accepted.
// Jump and long jump step the state update unit 256 times while the jump
// polynomial is scanned one bit a cycle. Jumps and loads produce no output
// transaction. The state resets to all zero, which yields zeros until a seed
// is loaded.
`timescale 1ns / 1ps
`default_nettype none

module xoshiro256_plusplus_generator (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  xsr_cmd_if.sink    in_i,
  xsr_rnd_if.source  out_o
);
  import xsr_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_NFIN,
    S_WALK
  } st_e;

  st_e        st_q, st_d;
  state_t     gen_q, gen_d;
  state_t     acc_q, acc_d;
  logic [7:0] cnt_q, cnt_d;
  logic       sel_long_q, sel_long_d;
  logic       out_valid_q, out_valid_d;
  word_t      out_data_q, out_data_d;
  word_t      sum_q, sum_d;
  word_t      s0_q, s0_d;

  state_t     gen_step;
  word_t      poly_word;
  logic       poly_bit;
  logic       in_fire;
  logic       out_fire;

  // Shared state update unit
  xsr_step u_step (
    .state_i (gen_q),
    .state_o (gen_step)
  );

  assign in_i.ready         = (st_q == S_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.random_value = out_data_q;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_valid_q && out_o.ready;

  // Current jump polynomial bit
  assign poly_word = sel_long_q ? LONG_JUMP_POLY[cnt_q[7:6]] : JUMP_POLY[cnt_q[7:6]];
  assign poly_bit  = poly_word[cnt_q[5:0]];

  // Sequencer
  always_comb begin
    st_d        = st_q;
    gen_d       = gen_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    sel_long_d  = sel_long_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    sum_d       = sum_q;
    s0_d        = s0_q;

    if (out_fire) begin
      out_valid_d = 1'b0;
    end

    case (st_q)
      S_IDLE: begin
        if (in_fire) begin
          case (func_e'(in_i.func))
            FUNC_NEXT: begin
              sum_d = gen_q[0] + gen_q[3];
              s0_d  = gen_q[0];
              gen_d = gen_step;
              st_d  = S_NFIN;
            end
            FUNC_JUMP, FUNC_LONG_JUMP: begin
              sel_long_d = (func_e'(in_i.func) == FUNC_LONG_JUMP);
              acc_d      = '0;
              cnt_d      = '0;
              st_d       = S_WALK;
            end
            default: begin
              gen_d[0] = in_i.seed_word0;
              gen_d[1] = in_i.seed_word1;
              gen_d[2] = in_i.seed_word2;
              gen_d[3] = in_i.seed_word3;
            end
          endcase
        end
      end
      S_NFIN: begin
        // finish the output once the output register is free
        if (!out_valid_q || out_o.ready) begin
          out_data_d  = rotl(sum_q, ROT_OUT) + s0_q;
          out_valid_d = 1'b1;
          st_d        = S_IDLE;
        end
      end
      S_WALK: begin
        acc_d = poly_bit ? (acc_q ^ gen_q) : acc_q;
        gen_d = gen_step;
        cnt_d = cnt_q + 8'd1;
        if (cnt_q == 8'hff) begin
          gen_d = acc_d;
          st_d  = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  // Control state, generator state, working registers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      gen_q       <= '0;
      acc_q       <= '0;
      cnt_q       <= '0;
      sel_long_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      sum_q       <= '0;
      s0_q        <= '0;
    end else begin
      st_q        <= st_d;
      gen_q       <= gen_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      sel_long_q  <= sel_long_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
      sum_q       <= sum_d;
      s0_q        <= s0_d;
    end
  end

  // Checks
  a_walk_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_WALK |-> !in_i.ready)
    else $error("command accepted during jump walk");

  a_next_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.func == FUNC_NEXT |=> st_q == S_NFIN)
    else $error("next command did not enter finish step");

  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.func == FUNC_LOAD |=>
      gen_q[0] == $past(in_i.seed_word0) && gen_q[3] == $past(in_i.seed_word3))
    else $error("seed load did not reach state");

  a_walk_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_i.func == FUNC_JUMP || in_i.func == FUNC_LONG_JUMP) |=>
      st_q == S_WALK && cnt_q == 8'd0)
    else $error("jump walk did not start at bit zero");

endmodule

`default_nettype wire
